@@ hdl/form_urlencoded_query_parser_macros.svh @@
// Assertion helpers shared by the RTL of the query parser.
`ifndef FORM_URLENCODED_QUERY_PARSER_MACROS_SVH
`define FORM_URLENCODED_QUERY_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FUQP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define FUQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hdl/fuqp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fuqp_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] MAX_PAIRS_RST = 8'd32;
  localparam int unsigned RES_MAX      = 4;

  typedef enum logic [1:0] {
    REC_DATA     = 2'd0,
    REC_PAIR_END = 2'd1,
    REC_TEXT_END = 2'd2
  } rec_kind_t;

  // Escape tracker: idle, after '%', after '%' and one hex digit.
  typedef enum logic [2:0] {
    ESC_NONE  = 3'b001,
    ESC_PCT   = 3'b010,
    ESC_DIGIT = 3'b100
  } esc_t;

  typedef struct packed {
    logic       in_value;
    logic       seg_open;
    esc_t       esc;
    logic [7:0] esc_first;
    logic [7:0] pairs_done;
    logic       dropping;
  } fuqp_state_t;

  typedef struct packed {
    rec_kind_t  record;
    logic       part;
    logic [7:0] data;
    logic       truncated;
    logic [7:0] pair_total;
    logic       final_res;
  } fuqp_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  function automatic fuqp_res_t mk_res(input rec_kind_t kind, input logic part,
                                       input logic [7:0] data, input logic trunc,
                                       input logic [7:0] total);
    fuqp_res_t r;
    r.record     = kind;
    r.part       = part;
    r.data       = data;
    r.truncated  = trunc;
    r.pair_total = total;
    r.final_res  = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/fuqp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface fuqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface fuqp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] record;
  logic       part;
  logic [7:0] data;
  logic       truncated;
  logic [7:0] pair_total;
  logic       final_res;
  modport source (output valid, record, part, data, truncated, pair_total, final_res,
                  input ready);
  modport sink (input valid, record, part, data, truncated, pair_total, final_res,
                output ready);
endinterface

interface fuqp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hdl/form_urlencoded_query_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload                                              Transfer
// in_chan   in   in_byte[7:0], last_byte                              valid & ready
// out_chan  out  record[1:0], part, data[7:0], truncated,             valid & ready
//                pair_total[7:0], final_res
// cfg_chan  in   data[7:0] -> max_pairs                               valid & ready
//
// A byte lands in the input register, then the decode logic turns it
// into 0 to 4 results that are loaded into a four-entry result buffer.
// Sustained rate: one byte per cycle while each byte yields at most one result
// and out_chan is ready; a byte with several results holds the input until the
// single result port has drained the buffer down to its last entry.
// rst_n is synchronous: max_pairs returns to 32, parse state and buffer clear;
// in_chan and cfg_chan refuse transfers while rst_n is low.
// A stall on out_chan backs up into in_chan after one buffered byte.
module form_urlencoded_query_parser
  import fuqp_pkg::*;
#(
  parameter int unsigned PAIR_LIMIT = 255
) (
  input  wire        clk,
  input  wire        rst_n,
  fuqp_in_if.sink    in_chan,
  fuqp_out_if.source out_chan,
  fuqp_cfg_if.sink   cfg_chan
);

  // effective limit never exceeds what the 8-bit pair counter holds
  localparam int unsigned LimClamp = (PAIR_LIMIT > 255) ? 255 : PAIR_LIMIT;
  localparam logic [7:0]  LIM8     = 8'(LimClamp);

  // input register
  logic            in_v_r;
  logic [7:0]      in_byte_r;
  logic            last_r;

  // parse state and configuration
  fuqp_state_t     state_r;
  fuqp_state_t     state_nxt;
  logic [7:0]      max_pairs_r;
  logic [7:0]      cap;

  // result buffer, head at entry 0
  fuqp_res_t [3:0] rbuf_r;
  fuqp_res_t [3:0] rbuf_nxt;
  logic [2:0]      cnt_r;
  logic [2:0]      cnt_nxt;

  fuqp_res_t [3:0] step_res;
  logic [2:0]      step_cnt;
  logic            load;
  logic            pop;

  assign cap = (max_pairs_r < LIM8) ? max_pairs_r : LIM8;

  fuqp_step u_step (
    .cur     (state_r),
    .c       (in_byte_r),
    .last    (last_r),
    .cap     (cap),
    .nxt     (state_nxt),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  // Decode the held byte once the buffer is empty or about to be.
  assign pop  = (cnt_r != 3'd0) && out_chan.ready;
  assign load = in_v_r && ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_chan.ready));

  assign in_chan.ready = rst_n && (!in_v_r || load);
  assign cfg_chan.ready = rst_n;

  assign out_chan.valid      = (cnt_r != 3'd0);
  assign out_chan.record     = rbuf_r[0].record;
  assign out_chan.part       = rbuf_r[0].part;
  assign out_chan.data       = rbuf_r[0].data;
  assign out_chan.truncated  = rbuf_r[0].truncated;
  assign out_chan.pair_total = rbuf_r[0].pair_total;
  assign out_chan.final_res  = rbuf_r[0].final_res;

  always_comb begin
    rbuf_nxt = rbuf_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      // replace the buffer wholesale: any remaining entry is taken this cycle
      rbuf_nxt = step_res;
      cnt_nxt  = step_cnt;
    end else if (pop) begin
      // advance the queue by one entry
      rbuf_nxt = {fuqp_res_t'('0), rbuf_r[3:1]};
      cnt_nxt  = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      state_r       <= '{in_value: 1'b0, seg_open: 1'b0, esc: ESC_NONE,
                         esc_first: 8'h00, pairs_done: 8'h00, dropping: 1'b0};
      max_pairs_r   <= MAX_PAIRS_RST;
      cnt_r         <= '0;
    end else begin
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
      end
      if (load) begin
        state_r <= state_nxt;
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        max_pairs_r <= cfg_chan.data;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.in_byte;
      last_r    <= in_chan.last_byte;
    end
    rbuf_r <= rbuf_nxt;
  end

`include "form_urlencoded_query_parser_macros.svh"

  // a held byte that is not decoded stays put
  `FUQP_ASSERT_NEXT(a_hold_input, clk, rst_n, in_v_r && !load, in_v_r && $stable(in_byte_r) && $stable(last_r))
  // the last buffered entry closes its byte's results
  `FUQP_ASSERT_IMPLY(a_tail_final, clk, rst_n, cnt_r == 3'd1, rbuf_r[0].final_res)
  // earlier entries never carry the closing flag
  `FUQP_ASSERT_IMPLY(a_head_not_final, clk, rst_n, cnt_r > 3'd1, !rbuf_r[0].final_res)
  // discarding only starts between segments, so no segment is open then
  `FUQP_ASSERT_IMPLY(a_drop_closed, clk, rst_n, state_r.dropping, !state_r.seg_open)

endmodule
`default_nettype wire

@@ hdl/fuqp_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fuqp_step
  import fuqp_pkg::*;
(
  input  fuqp_state_t         cur,
  input  logic [7:0]          c,
  input  logic                last,
  input  logic [7:0]          cap,
  output fuqp_state_t         nxt,
  output fuqp_res_t [3:0]     res,
  output logic [2:0]          res_cnt
);

  fuqp_state_t     s;
  fuqp_res_t [6:0] cand;
  logic [6:0]      cv;
  hex_t            hc;
  hex_t            hf;
  logic            do_plain;
  logic [7:0]      main_b;
  logic [2:0]      n;

  always_comb begin
    s        = cur;
    hc       = hex_val(c);
    hf       = hex_val(cur.esc_first);
    do_plain = 1'b0;
    main_b   = c;
    cv       = '0;
    n        = '0;
    res      = '0;

    // cv order: '%', held digit, main byte, end of pair, end-flush '%',
    // end-flush digit, end of text
    if (!s.dropping) begin
      if (!s.seg_open) begin
        if (s.pairs_done >= cap) begin
          s.dropping = 1'b1;
        end else if (c != CH_AMP) begin
          s.seg_open = 1'b1;
        end
      end
      if (!s.dropping && s.seg_open) begin
        if (c == CH_AMP) begin
          cv[0]        = (s.esc != ESC_NONE);
          cv[1]        = (s.esc == ESC_DIGIT);
          cv[3]        = 1'b1;
          s.esc        = ESC_NONE;
          s.pairs_done = s.pairs_done + 8'd1;
          s.seg_open   = 1'b0;
          s.in_value   = 1'b0;
        end else if (c == CH_EQ && !s.in_value) begin
          cv[0]      = (s.esc != ESC_NONE);
          cv[1]      = (s.esc == ESC_DIGIT);
          s.esc      = ESC_NONE;
          s.in_value = 1'b1;
        end else begin
          do_plain = 1'b1;
          case (s.esc)
            ESC_PCT: begin
              if (hc.ok) begin
                s.esc_first = c;
                s.esc       = ESC_DIGIT;
                do_plain    = 1'b0;
              end else begin
                s.esc = ESC_NONE;
                cv[0] = 1'b1;
              end
            end
            ESC_DIGIT: begin
              s.esc = ESC_NONE;
              if (hf.ok && hc.ok && {hf.val, hc.val} != 8'd0) begin
                cv[2]    = 1'b1;
                main_b   = {hf.val, hc.val};
                do_plain = 1'b0;
              end else begin
                cv[0] = 1'b1;
                cv[1] = 1'b1;
              end
            end
            default: s.esc = ESC_NONE;
          endcase
          if (do_plain) begin
            if (c == CH_PCT) begin
              s.esc = ESC_PCT;
            end else begin
              cv[2]  = 1'b1;
              main_b = (c == CH_PLUS) ? CH_SPACE : c;
            end
          end
        end
      end
    end

    if (last) begin
      if (!s.dropping && s.seg_open) begin
        cv[4]        = (s.esc != ESC_NONE);
        cv[5]        = (s.esc == ESC_DIGIT);
        s.pairs_done = s.pairs_done + 8'd1;
      end
      cv[6] = 1'b1;
    end

    cand[0] = mk_res(REC_DATA, cur.in_value, CH_PCT, 1'b0, 8'd0);
    cand[1] = mk_res(REC_DATA, cur.in_value, cur.esc_first, 1'b0, 8'd0);
    cand[2] = mk_res(REC_DATA, cur.in_value, main_b, 1'b0, 8'd0);
    cand[3] = mk_res(REC_PAIR_END, 1'b0, 8'd0, 1'b0, 8'd0);
    cand[4] = mk_res(REC_DATA, s.in_value, CH_PCT, 1'b0, 8'd0);
    cand[5] = mk_res(REC_DATA, s.in_value, s.esc_first, 1'b0, 8'd0);
    cand[6] = mk_res(REC_TEXT_END, 1'b0, 8'd0, s.dropping, s.pairs_done);

    // pack the live candidates into the first slots, in order
    for (int i = 0; i < 7; i++) begin
      if (cv[i] && n < 3'(RES_MAX)) begin
        res[n[1:0]] = cand[i];
        n           = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      res[2'(n - 3'd1)].final_res = 1'b1;
    end
    res_cnt = n;

    if (last) begin
      nxt           = '0;
      nxt.esc       = ESC_NONE;
    end else begin
      nxt = s;
    end
  end

endmodule
`default_nettype wire
